[src/iast_pkg.sv]
// ----------------------------------------------------------------------------
// iast_pkg
// Types, codes and defaults shared by the address set table modules.
// ----------------------------------------------------------------------------
package iast_pkg;

  localparam int TABLE_ENTRIES_DEF = 32;

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_LIST   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2,
    ST_LIST = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_SHIFT,
    S_RESP,
    S_LIST_RD,
    S_LIST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic        is_ipv6;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        entry_valid;
    logic [63:0] out_addr_hi;
    logic [63:0] out_addr_lo;
    logic        out_is_ipv6;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic        is_ipv6;
  } entry_t;

  typedef struct packed {
    logic    accept;
    logic    rd_issue;
    logic    scan_chk;
    logic    append;
    logic    shift_init;
    logic    shift_wr;
    logic    count_dec;
    logic    out_load;
    logic    out_entry;
    status_e out_status;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] in_req_type;
    logic [1:0] req_type;
    logic       found;
    logic       hit;
    logic       scan_end;
    logic       count_zero;
    logic       full;
    logic       rd_pend;
    logic       ptr_end;
    logic       entry_last;
    logic       out_free;
  } dp_stat_t;

endpackage

[src/iast_datapath.sv]
// ----------------------------------------------------------------------------
// iast_datapath
// Entry memory, scan pointer, comparator, entry count and output register.
// ----------------------------------------------------------------------------
module iast_datapath #(
  parameter int TABLE_ENTRIES = iast_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  iast_pkg::in_item_t  in_data,
  input  iast_pkg::dp_cmd_t   cmd,
  output iast_pkg::dp_stat_t  stat,
  output logic                out_valid,
  input  logic                out_stall,
  output iast_pkg::out_item_t out_data
);

  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);
  localparam logic [CNT_W-1:0] ONE      = CNT_W'(1);

  iast_pkg::entry_t    mem [TABLE_ENTRIES];

  iast_pkg::in_item_t  req_r,       req_nxt;
  logic [CNT_W-1:0]    count_r,     count_nxt;
  logic [CNT_W-1:0]    ptr_r,       ptr_nxt;
  logic [CNT_W-1:0]    rd_idx_r,    rd_idx_nxt;
  logic                rd_vld_r,    rd_vld_nxt;
  logic                found_r,     found_nxt;
  logic [CNT_W-1:0]    pos_r,       pos_nxt;
  logic                out_valid_r, out_valid_nxt;
  iast_pkg::out_item_t out_data_r,  out_data_nxt;
  iast_pkg::entry_t    rd_data_r;

  logic                rd_go;
  logic                hit;
  logic                entry_last;
  logic                out_free;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [CNT_W-1:0]    rd_idx_m1;
  iast_pkg::entry_t    wr_entry;
  iast_pkg::out_item_t resp;

  assign rd_go      = cmd.rd_issue && (ptr_r < count_r);
  assign hit        = rd_vld_r && (rd_data_r.addr_hi == req_r.addr_hi)
                      && (rd_data_r.addr_lo == req_r.addr_lo);
  assign entry_last = (rd_idx_r + ONE) == count_r;
  assign out_free   = !out_valid_r || !out_stall;
  assign rd_idx_m1  = rd_idx_r - ONE;

  assign wr_en    = cmd.append || (cmd.shift_wr && rd_vld_r);
  assign wr_addr  = cmd.append ? count_r[IDX_W-1:0] : rd_idx_m1[IDX_W-1:0];
  assign wr_entry = cmd.append ? iast_pkg::entry_t'{addr_hi: req_r.addr_hi,
                                                    addr_lo: req_r.addr_lo,
                                                    is_ipv6: req_r.is_ipv6}
                               : rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_go) begin
      rd_data_r <= mem[ptr_r[IDX_W-1:0]];
    end
  end

  always_comb begin
    resp.status      = 2'(cmd.out_status);
    resp.entry_valid = cmd.out_entry;
    resp.out_addr_hi = cmd.out_entry ? rd_data_r.addr_hi : 64'd0;
    resp.out_addr_lo = cmd.out_entry ? rd_data_r.addr_lo : 64'd0;
    resp.out_is_ipv6 = cmd.out_entry ? rd_data_r.is_ipv6 : 1'b0;
    resp.last        = cmd.out_entry ? entry_last : 1'b1;
  end

  always_comb begin
    req_nxt       = cmd.accept ? in_data : req_r;
    ptr_nxt       = ptr_r;
    rd_idx_nxt    = rd_idx_r;
    rd_vld_nxt    = rd_go;
    found_nxt     = found_r;
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cmd.accept) begin
      ptr_nxt   = '0;
      found_nxt = 1'b0;
    end else if (cmd.shift_init) begin
      ptr_nxt = pos_r + ONE;
    end else if (rd_go) begin
      ptr_nxt = ptr_r + ONE;
    end
    if (rd_go) begin
      rd_idx_nxt = ptr_r;
    end
    if (cmd.scan_chk && hit) begin
      found_nxt = 1'b1;
      pos_nxt   = rd_idx_r;
    end
    if (cmd.append) begin
      count_nxt = count_r + ONE;
    end else if (cmd.count_dec) begin
      count_nxt = count_r - ONE;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = resp;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    rd_idx_r   <= rd_idx_nxt;
    pos_r      <= pos_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      count_r     <= '0;
      ptr_r       <= '0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      rd_vld_r    <= rd_vld_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    stat.in_req_type = in_data.req_type;
    stat.req_type    = req_r.req_type;
    stat.found       = found_r;
    stat.hit         = hit;
    stat.scan_end    = rd_vld_r && entry_last;
    stat.count_zero  = count_r == '0;
    stat.full        = count_r >= FULL_CNT;
    stat.rd_pend     = rd_vld_r;
    stat.ptr_end     = ptr_r >= count_r;
    stat.entry_last  = entry_last;
    stat.out_free    = out_free;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[src/iast_controller.sv]
// ----------------------------------------------------------------------------
// iast_controller
// Request sequencer: scan, append, shift-down on remove, list walk, reply.
// ----------------------------------------------------------------------------
module iast_controller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  iast_pkg::dp_stat_t stat,
  output iast_pkg::dp_cmd_t  cmd
);

  iast_pkg::state_t  state_r, state_nxt;
  iast_pkg::status_e resp_r,  resp_nxt;

  always_comb begin
    state_nxt = state_r;
    resp_nxt  = resp_r;
    case (state_r)
      iast_pkg::S_IDLE: begin
        if (in_valid) begin
          if (stat.in_req_type == iast_pkg::REQ_LIST) begin
            if (stat.count_zero) begin
              resp_nxt  = iast_pkg::ST_LIST;
              state_nxt = iast_pkg::S_RESP;
            end else begin
              state_nxt = iast_pkg::S_LIST_RD;
            end
          end else if (stat.count_zero) begin
            state_nxt = iast_pkg::S_FINISH;
          end else begin
            state_nxt = iast_pkg::S_SCAN;
          end
        end
      end
      iast_pkg::S_SCAN: begin
        if (stat.hit || stat.scan_end) begin
          state_nxt = iast_pkg::S_FINISH;
        end
      end
      iast_pkg::S_FINISH: begin
        state_nxt = iast_pkg::S_RESP;
        case (stat.req_type)
          iast_pkg::REQ_LOOKUP: begin
            resp_nxt = stat.found ? iast_pkg::ST_DONE : iast_pkg::ST_MISS;
          end
          iast_pkg::REQ_ADD: begin
            if (stat.found) begin
              resp_nxt = iast_pkg::ST_MISS;
            end else if (stat.full) begin
              resp_nxt = iast_pkg::ST_FULL;
            end else begin
              resp_nxt = iast_pkg::ST_DONE;
            end
          end
          iast_pkg::REQ_REMOVE: begin
            if (stat.found) begin
              state_nxt = iast_pkg::S_SHIFT;
            end else begin
              resp_nxt = iast_pkg::ST_MISS;
            end
          end
          default: begin
            resp_nxt = iast_pkg::ST_DONE;
          end
        endcase
      end
      iast_pkg::S_SHIFT: begin
        if (stat.ptr_end && !stat.rd_pend) begin
          resp_nxt  = iast_pkg::ST_DONE;
          state_nxt = iast_pkg::S_RESP;
        end
      end
      iast_pkg::S_RESP: begin
        if (stat.out_free) begin
          state_nxt = iast_pkg::S_IDLE;
        end
      end
      iast_pkg::S_LIST_RD: begin
        state_nxt = iast_pkg::S_LIST_OUT;
      end
      iast_pkg::S_LIST_OUT: begin
        if (stat.out_free) begin
          state_nxt = stat.entry_last ? iast_pkg::S_IDLE : iast_pkg::S_LIST_RD;
        end
      end
      default: begin
        state_nxt = iast_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.out_status = resp_r;
    in_stall       = 1'b1;
    case (state_r)
      iast_pkg::S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      iast_pkg::S_SCAN: begin
        cmd.rd_issue = 1'b1;
        cmd.scan_chk = 1'b1;
      end
      iast_pkg::S_FINISH: begin
        if (stat.req_type == iast_pkg::REQ_ADD) begin
          cmd.append = !stat.found && !stat.full;
        end
        if (stat.req_type == iast_pkg::REQ_REMOVE) begin
          cmd.shift_init = stat.found;
        end
      end
      iast_pkg::S_SHIFT: begin
        cmd.rd_issue  = 1'b1;
        cmd.shift_wr  = 1'b1;
        cmd.count_dec = stat.ptr_end && !stat.rd_pend;
      end
      iast_pkg::S_RESP: begin
        cmd.out_load = stat.out_free;
      end
      iast_pkg::S_LIST_RD: begin
        cmd.rd_issue = 1'b1;
      end
      iast_pkg::S_LIST_OUT: begin
        cmd.out_load   = stat.out_free;
        cmd.out_entry  = 1'b1;
        cmd.out_status = iast_pkg::ST_LIST;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    resp_r <= resp_nxt;
    if (!rst_n) begin
      state_r <= iast_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[src/ip_address_set_table_core.sv]
// ----------------------------------------------------------------------------
// ip_address_set_table_core
// Ordered set of 128-bit addresses with lookup, add, remove and list.
// ----------------------------------------------------------------------------
// One request is taken at a time. Lookup, add and remove read the entry
// memory one slot per cycle through its single read port into one 128-bit
// comparator, stopping early when the address is found. A remove that hits
// then moves every later entry down a slot, one per cycle. A list reads each
// entry from memory, then loads it into the output register, and waits on
// out_stall. A finished result sits in the output register while the next
// request is accepted. No clearing pass is needed after reset: only slots
// below the entry count are ever read.
module ip_address_set_table_core #(
  parameter int TABLE_ENTRIES = iast_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  iast_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output iast_pkg::out_item_t out_data
);

  iast_pkg::dp_cmd_t  cmd;
  iast_pkg::dp_stat_t stat;

  iast_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  iast_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ordered 128-bit address set table.
// ----------------------------------------------------------------------------
// Directed requests walk through the empty table, duplicates, near misses,
// removal with compaction and listing. Random requests then draw addresses
// from a small pool so that adds, hits, removals and a full table all occur.
// A scoreboard keeps its own copy of the table. It predicts every reply and
// compares each accepted reply with the oldest prediction. Sender gaps and
// receiver stalls vary by phase. One phase holds the receiver off long
// enough to back up the input channel.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DEPTH      = iast_pkg::TABLE_ENTRIES_DEF;
  localparam int POOL_SIZE  = 40;
  localparam int LIMIT      = 400000;
  localparam int DRAIN      = 80;
  localparam int HOLD_OFF   = 600;

  class addr_set_scoreboard;
    iast_pkg::entry_t    slots[DEPTH];
    int unsigned         fill;
    iast_pkg::out_item_t replies_due[$];
    int unsigned         errors;
    int unsigned         requests;
    int unsigned         replies;
    int unsigned         full_hits;
    int unsigned         lists;

    function new();
      fill = 0;
      errors = 0;
      requests = 0;
      replies = 0;
      full_hits = 0;
      lists = 0;
    endfunction

    function void push_reply(iast_pkg::status_e st, logic vld, iast_pkg::entry_t e,
                             logic lst);
      iast_pkg::out_item_t r;
      r.status      = st;
      r.entry_valid = vld;
      r.out_addr_hi = e.addr_hi;
      r.out_addr_lo = e.addr_lo;
      r.out_is_ipv6 = e.is_ipv6;
      r.last        = lst;
      replies_due.push_back(r);
    endfunction

    function void note_request(iast_pkg::in_item_t req);
      int               pos;
      iast_pkg::entry_t blank;
      iast_pkg::entry_t fresh;
      blank = '0;
      pos = -1;
      requests++;
      for (int i = 0; i < fill; i++) begin
        if (pos < 0 && slots[i].addr_hi == req.addr_hi && slots[i].addr_lo == req.addr_lo) begin
          pos = i;
        end
      end
      case (iast_pkg::req_e'(req.req_type))
        iast_pkg::REQ_LIST: begin
          lists++;
          if (fill == 0) begin
            push_reply(iast_pkg::ST_LIST, 1'b0, blank, 1'b1);
          end else begin
            for (int i = 0; i < fill; i++) begin
              push_reply(iast_pkg::ST_LIST, 1'b1, slots[i], i == fill - 1);
            end
          end
        end
        iast_pkg::REQ_LOOKUP: begin
          push_reply(pos >= 0 ? iast_pkg::ST_DONE : iast_pkg::ST_MISS, 1'b0, blank, 1'b1);
        end
        iast_pkg::REQ_ADD: begin
          if (pos >= 0) begin
            push_reply(iast_pkg::ST_MISS, 1'b0, blank, 1'b1);
          end else if (fill >= DEPTH) begin
            full_hits++;
            push_reply(iast_pkg::ST_FULL, 1'b0, blank, 1'b1);
          end else begin
            fresh.addr_hi = req.addr_hi;
            fresh.addr_lo = req.addr_lo;
            fresh.is_ipv6 = req.is_ipv6;
            slots[fill] = fresh;
            fill++;
            push_reply(iast_pkg::ST_DONE, 1'b0, blank, 1'b1);
          end
        end
        default: begin
          if (pos < 0) begin
            push_reply(iast_pkg::ST_MISS, 1'b0, blank, 1'b1);
          end else begin
            for (int i = pos; i + 1 < fill; i++) begin
              slots[i] = slots[i + 1];
            end
            fill--;
            push_reply(iast_pkg::ST_DONE, 1'b0, blank, 1'b1);
          end
        end
      endcase
    endfunction

    function void check_result(iast_pkg::out_item_t got);
      iast_pkg::out_item_t want;
      replies++;
      if (replies_due.size() == 0) begin
        $error("unexpected reply: status %0d last %0d", got.status, got.last);
        errors++;
        return;
      end
      want = replies_due.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.entry_valid !== want.entry_valid) begin
        $error("entry_valid: expected %0d, got %0d", want.entry_valid, got.entry_valid);
        errors++;
      end
      if (got.out_addr_hi !== want.out_addr_hi) begin
        $error("out_addr_hi: expected %h, got %h", want.out_addr_hi, got.out_addr_hi);
        errors++;
      end
      if (got.out_addr_lo !== want.out_addr_lo) begin
        $error("out_addr_lo: expected %h, got %h", want.out_addr_lo, got.out_addr_lo);
        errors++;
      end
      if (got.out_is_ipv6 !== want.out_is_ipv6) begin
        $error("out_is_ipv6: expected %0d, got %0d", want.out_is_ipv6, got.out_is_ipv6);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  iast_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  iast_pkg::out_item_t out_data;

  logic          hold_off = 1'b0;
  int            idle_pct = 0;
  int            stall_pct = 0;
  int unsigned   cycle_cnt = 0;
  logic [127:0]  addr_pool[POOL_SIZE];
  addr_set_scoreboard sb;

  ip_address_set_table_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end
  end

  // inputs change only at rising edges, so negedge values are the edge values
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_data);
    end
  end

  function automatic iast_pkg::in_item_t mk_req(iast_pkg::req_e kind, logic [127:0] addr,
                                                logic v6);
    iast_pkg::in_item_t r;
    r.req_type = kind;
    r.addr_hi  = addr[127:64];
    r.addr_lo  = addr[63:0];
    r.is_ipv6  = v6;
    return r;
  endfunction

  function automatic logic [127:0] pick_addr();
    logic [127:0] a;
    case ($urandom_range(9))
      0: a = {$urandom, $urandom, $urandom, $urandom};
      1: begin
        a = addr_pool[$urandom_range(POOL_SIZE - 1)];
        a[$urandom_range(127)] ^= 1'b1;
      end
      default: a = addr_pool[$urandom_range(POOL_SIZE - 1)];
    endcase
    return a;
  endfunction

  function automatic iast_pkg::in_item_t rand_req(int add_pct);
    int             r;
    iast_pkg::req_e kind;
    r = $urandom_range(99);
    if (r < add_pct) begin
      kind = iast_pkg::REQ_ADD;
    end else if (r < 90) begin
      kind = $urandom_range(1) ? iast_pkg::REQ_REMOVE : iast_pkg::REQ_LOOKUP;
    end else begin
      kind = iast_pkg::REQ_LIST;
    end
    return mk_req(kind, pick_addr(), 1'($urandom_range(1)));
  endfunction

  // called at a rising edge; returns at the edge that accepts the transaction
  task automatic send_item(iast_pkg::in_item_t item);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(negedge clk);
    while (in_stall) begin
      @(negedge clk);
    end
    sb.note_request(item);
    @(posedge clk);
  endtask

  task automatic run_random(int count, int add_pct);
    for (int i = 0; i < count; i++) begin
      send_item(rand_req(add_pct));
    end
  endtask

  task automatic run_directed();
    logic [127:0] zero;
    logic [127:0] ones;
    logic [127:0] lo_one;
    logic [127:0] hi_ones;
    zero    = '0;
    ones    = '1;
    lo_one  = 128'd1;
    hi_ones = {64'hFFFF_FFFF_FFFF_FFFF, 64'h0};
    send_item(mk_req(iast_pkg::REQ_LIST,   ones,    1'b1));
    send_item(mk_req(iast_pkg::REQ_LOOKUP, zero,    1'b0));
    send_item(mk_req(iast_pkg::REQ_REMOVE, ones,    1'b1));
    send_item(mk_req(iast_pkg::REQ_ADD,    zero,    1'b0));
    send_item(mk_req(iast_pkg::REQ_ADD,    ones,    1'b1));
    // duplicate add keeps the stored tag
    send_item(mk_req(iast_pkg::REQ_ADD,    ones,    1'b0));
    send_item(mk_req(iast_pkg::REQ_ADD,    lo_one,  1'b1));
    send_item(mk_req(iast_pkg::REQ_ADD,    hi_ones, 1'b0));
    send_item(mk_req(iast_pkg::REQ_LOOKUP, ones,    1'b0));
    send_item(mk_req(iast_pkg::REQ_LOOKUP, ones ^ 128'd1, 1'b1));
    send_item(mk_req(iast_pkg::REQ_LOOKUP, zero,    1'b1));
    send_item(mk_req(iast_pkg::REQ_LIST,   zero,    1'b0));
    send_item(mk_req(iast_pkg::REQ_REMOVE, zero,    1'b1));
    send_item(mk_req(iast_pkg::REQ_LIST,   ones,    1'b0));
    send_item(mk_req(iast_pkg::REQ_REMOVE, hi_ones, 1'b0));
    send_item(mk_req(iast_pkg::REQ_REMOVE, zero,    1'b0));
    send_item(mk_req(iast_pkg::REQ_LIST,   lo_one,  1'b1));
    send_item(mk_req(iast_pkg::REQ_ADD,    zero,    1'b1));
    send_item(mk_req(iast_pkg::REQ_LIST,   zero,    1'b1));
  endtask

  initial begin
    sb = new();
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    addr_pool[2] = {64'h0, 64'hFFFF_FFFF_FFFF_FFFF};
    addr_pool[3] = {64'hFFFF_FFFF_FFFF_FFFF, 64'h0};
    for (int i = 4; i < POOL_SIZE; i++) begin
      addr_pool[i] = {$urandom, $urandom, $urandom, $urandom};
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    idle_pct = 0;
    stall_pct = 0;
    run_random(60, 65);

    idle_pct = 57;
    stall_pct = 0;
    run_random(40, 35);

    idle_pct = 0;
    stall_pct = 57;
    run_random(40, 35);

    idle_pct = 30;
    stall_pct = 30;
    run_random(40, 40);

    // receiver backs off while requests keep coming
    idle_pct = 0;
    stall_pct = 0;
    fork
      run_random(25, 40);
      begin
        hold_off <= 1'b1;
        repeat (HOLD_OFF) @(posedge clk);
        hold_off <= 1'b0;
      end
    join
    in_valid <= 1'b0;

    while (sb.replies_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN) @(posedge clk);

    $display("%0d requests (%0d lists), %0d replies checked, %0d adds refused as full",
             sb.requests, sb.lists, sb.replies, sb.full_hits);
    $display("%0d entries left in the table", sb.fill);
    if (sb.errors == 0 && sb.replies_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d replies missing", sb.errors, sb.replies_due.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
